// ----- design/pifd_pkg.sv -----
// ----------------------------------------------------------------------------
// pifd_pkg: shared types and constants of the pulse interval frame decoder
// Field widths, register indexes, reset values and the shared slot-unit
// interface types.
// ----------------------------------------------------------------------------
package pifd_pkg;

    localparam int TIME_W  = 16;
    localparam int ADJ_W   = TIME_W + 1;
    localparam int BYTE_W  = 8;
    localparam int SMALL_W = 8;
    localparam int STAGE_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [STAGE_W-1:0] STAGE_IDLE = 4'd0;
    localparam logic [STAGE_W-1:0] STAGE_DONE = 4'd10;

    localparam logic [TIME_W-1:0]  GAP_LIMIT_RST      = 16'd100;
    localparam logic [SMALL_W-1:0] TOLERANCE_RST      = 8'd5;
    localparam logic [TIME_W-1:0]  ZERO_THRESHOLD_RST = 16'd20;
    localparam logic [SMALL_W-1:0] SLOT_LENGTH_RST    = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAP_LIMIT      = 2'd0,
        REG_TOLERANCE      = 2'd1,
        REG_ZERO_THRESHOLD = 2'd2,
        REG_SLOT_LENGTH    = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SLOT = 2'b10
    } state_t;

    // Operands of the shared slot unit.
    typedef struct packed {
        logic [ADJ_W-1:0]   adj;
        logic [TIME_W-1:0]  zero_threshold;
        logic [SMALL_W-1:0] slot_length;
        logic [STAGE_W-1:0] stage;
    } slot_req_t;

    // Verdict of the shared slot unit.
    typedef struct packed {
        logic             more;
        logic [ADJ_W-1:0] adj_next;
    } slot_rsp_t;

endpackage

// ----- design/pifd_if.sv -----
// ----------------------------------------------------------------------------
// pifd_if: valid/ready channels of the pulse interval frame decoder
// One interface for the edge requests and one for the received bytes.
// ----------------------------------------------------------------------------
interface pifd_edge_if;
    logic                        valid;
    logic                        ready;
    logic [pifd_pkg::TIME_W-1:0] edge_time;

    modport source (output valid, output edge_time, input ready);
    modport sink   (input valid, input edge_time, output ready);
endinterface

interface pifd_byte_if;
    logic                        valid;
    logic                        ready;
    logic [pifd_pkg::BYTE_W-1:0] received_byte;

    modport source (output valid, output received_byte, input ready);
    modport sink   (input valid, input received_byte, output ready);
endinterface

// ----- design/pifd_slot_unit.sv -----
// ----------------------------------------------------------------------------
// pifd_slot_unit: shared compare and subtract unit
// Decides whether another zero slot is counted and forms the remainder of
// the adjusted gap, saturating at zero.
// ----------------------------------------------------------------------------
module pifd_slot_unit (
    input  pifd_pkg::slot_req_t req,
    output pifd_pkg::slot_rsp_t rsp
);
    import pifd_pkg::*;

    logic [ADJ_W-1:0] slot_ext;

    assign slot_ext = {{(ADJ_W-SMALL_W){1'b0}}, req.slot_length};

    always_comb
    begin
        rsp.more = (req.adj > {1'b0, req.zero_threshold}) && (req.stage <= STAGE_DONE);
        if (req.adj > slot_ext)
        begin
            rsp.adj_next = req.adj - slot_ext;
        end
        else
        begin
            rsp.adj_next = '0;
        end
    end

endmodule

// ----- design/pifd_seq.sv -----
// ----------------------------------------------------------------------------
// pifd_seq: frame sequencer of the pulse interval frame decoder
// Holds the frame state, steps the shared slot unit once per cycle while
// an edge is counted, and loads the output register when a frame completes.
// ----------------------------------------------------------------------------
module pifd_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pifd_pkg::TIME_W-1:0]   gap_limit,
    input  logic [pifd_pkg::SMALL_W-1:0]  tolerance,
    input  logic [pifd_pkg::TIME_W-1:0]   zero_threshold,
    input  logic [pifd_pkg::SMALL_W-1:0]  slot_length,
    pifd_edge_if.sink                     pulse,
    pifd_byte_if.source                   result
);
    import pifd_pkg::*;

    state_t             state_reg, state_next;
    logic [TIME_W-1:0]  last_time_reg, last_time_next;
    logic [STAGE_W-1:0] stage_reg, stage_next;
    logic [BYTE_W-1:0]  shift_reg, shift_next;
    logic [ADJ_W-1:0]   adj_reg, adj_next;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;

    logic [TIME_W-1:0]  gap;
    logic               accept;
    logic               out_free;
    slot_req_t          slot_req;
    slot_rsp_t          slot_rsp;

    pifd_slot_unit u_slot (
        .req (slot_req),
        .rsp (slot_rsp)
    );

    assign slot_req.adj            = adj_reg;
    assign slot_req.zero_threshold = zero_threshold;
    assign slot_req.slot_length    = slot_length;
    assign slot_req.stage          = stage_reg;

    assign pulse.ready          = (state_reg == ST_IDLE);
    assign accept               = pulse.valid && pulse.ready;
    assign gap                  = pulse.edge_time - last_time_reg;
    assign out_free             = !out_valid_reg || result.ready;
    assign result.valid         = out_valid_reg;
    assign result.received_byte = out_byte_reg;

    always_comb
    begin
        state_next     = state_reg;
        last_time_next = last_time_reg;
        stage_next     = stage_reg;
        shift_next     = shift_reg;
        adj_next       = adj_reg;
        out_byte_next  = out_byte_reg;
        out_valid_next = out_valid_reg && !result.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_time_next = pulse.edge_time;
                    // A long gap, or an idle frame, makes this pulse the frame start.
                    if ((gap > gap_limit) || (stage_reg == STAGE_IDLE))
                    begin
                        stage_next = STAGE_W'(1);
                    end
                    else
                    begin
                        stage_next = stage_reg + STAGE_W'(1);
                        adj_next   = {1'b0, gap} + {{(ADJ_W-SMALL_W){1'b0}}, tolerance};
                        state_next = ST_SLOT;
                    end
                end
            end
            ST_SLOT:
            begin
                if (slot_rsp.more)
                begin
                    adj_next   = slot_rsp.adj_next;
                    stage_next = stage_reg + STAGE_W'(1);
                    shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                end
                else if (stage_reg > STAGE_DONE)
                begin
                    stage_next = STAGE_IDLE;
                    state_next = ST_IDLE;
                end
                else if (stage_reg == STAGE_DONE)
                begin
                    // Hold here until the output register can take the byte.
                    if (out_free)
                    begin
                        out_byte_next  = shift_reg;
                        out_valid_next = 1'b1;
                        stage_next     = STAGE_IDLE;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    shift_next = {shift_reg[BYTE_W-2:0], 1'b1};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_time_reg <= '0;
            stage_reg     <= STAGE_IDLE;
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_time_reg <= last_time_next;
            stage_reg     <= stage_next;
            shift_reg     <= shift_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        adj_reg      <= adj_next;
        out_byte_reg <= out_byte_next;
    end

endmodule

// ----- design/pulse_interval_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// pulse_interval_frame_decoder: pulse interval frame receiver
// Each request on the pulse channel is one detected edge with its 16-bit
// millisecond timestamp. The gap since the previous edge decides whether a
// frame starts, and how many zero slots precede the bit that this edge marks.
// Completed frame bytes leave on the result channel.
//
// Flow: an edge request is taken only when the sequencer is idle. A frame
// start is handled on acceptance alone; any other edge then steps the shared
// compare/subtract unit once per counted zero slot (at most nine) and then
// closes, and no new edge is taken until it has closed.
// A completed byte is registered and shown on the result channel; the block
// keeps taking edges while it waits. If the receiver still holds the previous
// byte when the next frame completes, the sequencer holds in its closing step.
// Configuration writes (gap_limit, tolerance, zero_threshold, slot_length)
// take effect at once and must be made while the block is idle; the block
// does not enforce this. Reset restores the register defaults, clears the
// timestamp and the shift register, and returns framing to idle.
// ----------------------------------------------------------------------------
module pulse_interval_frame_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pifd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pifd_pkg::CFG_DATA_W-1:0] cfg_data,
    pifd_edge_if.sink                       pulse,
    pifd_byte_if.source                     result
);
    import pifd_pkg::*;

    logic [TIME_W-1:0]  gap_limit_reg;
    logic [SMALL_W-1:0] tolerance_reg;
    logic [TIME_W-1:0]  zero_threshold_reg;
    logic [SMALL_W-1:0] slot_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_limit_reg      <= GAP_LIMIT_RST;
            tolerance_reg      <= TOLERANCE_RST;
            zero_threshold_reg <= ZERO_THRESHOLD_RST;
            slot_length_reg    <= SLOT_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAP_LIMIT:      gap_limit_reg      <= cfg_data[TIME_W-1:0];
                REG_TOLERANCE:      tolerance_reg      <= cfg_data[SMALL_W-1:0];
                REG_ZERO_THRESHOLD: zero_threshold_reg <= cfg_data[TIME_W-1:0];
                REG_SLOT_LENGTH:    slot_length_reg    <= cfg_data[SMALL_W-1:0];
                default:            gap_limit_reg      <= gap_limit_reg;
            endcase
        end
    end

    pifd_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .gap_limit      (gap_limit_reg),
        .tolerance      (tolerance_reg),
        .zero_threshold (zero_threshold_reg),
        .slot_length    (slot_length_reg),
        .pulse          (pulse),
        .result         (result)
    );

endmodule

// ----- test/tb_pulse_interval_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_pulse_interval_frame_decoder: self-checking bench of the frame decoder
// Drives timestamped pulse edges with random idling on both channels, keeps
// a cycle-free model of the gap, slot and shift logic to predict each frame
// byte, and compares every received byte in order. Runs a directed frame set
// and then random frames under several register settings, extremes included.
// ----------------------------------------------------------------------------
module tb_pulse_interval_frame_decoder;
    import pifd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int REPORT_MAX    = 10;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pifd_edge_if pulse_ch ();
    pifd_byte_if byte_ch ();

    pulse_interval_frame_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pulse     (pulse_ch),
        .result    (byte_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Register copies used by the byte predictor.
    logic [TIME_W-1:0]  cfg_gap_limit      = GAP_LIMIT_RST;
    logic [SMALL_W-1:0] cfg_tolerance      = TOLERANCE_RST;
    logic [TIME_W-1:0]  cfg_zero_threshold = ZERO_THRESHOLD_RST;
    logic [SMALL_W-1:0] cfg_slot_length    = SLOT_LENGTH_RST;

    // Decoder state as the predictor sees it.
    logic [TIME_W-1:0] last_edge = '0;
    int                frame_pos = 0;
    logic [BYTE_W-1:0] shift_reg = '0;

    logic [TIME_W-1:0] pending_times [$];
    logic [BYTE_W-1:0] expected_bytes [$];
    int directed_times [$] = '{0, 10, 20, 30, 40, 50, 60, 70, 80, 90,
                               65530, 4, 29, 64, 159, 260, 260, 270};

    logic [TIME_W-1:0] next_time = '0;
    int queued_total = 0;
    int idle_odds    = 0;
    int stall_odds   = 0;
    int idle_left    = 0;
    int stall_left   = 0;
    int fault_count  = 0;
    int cycle_count  = 0;

    // Works out what one accepted edge does to the frame and queues the byte
    // that it completes, if any.
    function automatic void predict_edge(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] gap;
        logic [ADJ_W-1:0]  adj;
        gap = now - last_edge;
        last_edge = now;
        if (gap > cfg_gap_limit)
            frame_pos = 0;
        if (frame_pos == 0)
        begin
            frame_pos = 1;
            return;
        end
        frame_pos++;
        adj = {1'b0, gap} + ADJ_W'(cfg_tolerance);
        // Slot counting stops once the frame has run past its last stage.
        while (adj > ADJ_W'(cfg_zero_threshold) && frame_pos <= int'(STAGE_DONE))
        begin
            adj = (adj > ADJ_W'(cfg_slot_length)) ? adj - ADJ_W'(cfg_slot_length) : '0;
            frame_pos++;
            shift_reg = shift_reg << 1;
        end
        if (frame_pos > int'(STAGE_DONE))
        begin
            frame_pos = 0;
            return;
        end
        if (frame_pos == int'(STAGE_DONE))
        begin
            expected_bytes.push_back(shift_reg);
            frame_pos = 0;
            return;
        end
        shift_reg = {shift_reg[BYTE_W-2:0], 1'b1};
    endfunction

    // Picks a gap that yields the wanted number of zero slots under the
    // current settings without restarting the frame, or any legal gap if
    // no such gap exists.
    function automatic int gap_for_zeros(input int zeros);
        int lo;
        int hi;
        if (zeros == 0)
        begin
            lo = 0;
            hi = int'(cfg_zero_threshold);
        end
        else
        begin
            lo = int'(cfg_zero_threshold) + (zeros - 1) * int'(cfg_slot_length) + 1;
            hi = int'(cfg_zero_threshold) + zeros * int'(cfg_slot_length);
        end
        lo = lo - int'(cfg_tolerance);
        hi = hi - int'(cfg_tolerance);
        if (lo < 0)
            lo = 0;
        if (hi > int'(cfg_gap_limit))
            hi = int'(cfg_gap_limit);
        if (lo > hi)
            return $urandom_range(0, cfg_gap_limit);
        return $urandom_range(lo, hi);
    endfunction

    task automatic queue_gap(input int gap);
        next_time = next_time + gap[TIME_W-1:0];
        pending_times.push_back(next_time);
        queued_total++;
    endtask

    // One frame: a start edge, then edges whose slot counts add up to the
    // final stage. Now and then the frame overshoots or is cut short.
    task automatic queue_frame();
        int budget;
        int zeros;
        budget = int'(STAGE_DONE) - 1;
        if ($urandom_range(0, 1) == 0 && cfg_gap_limit != '1)
            queue_gap($urandom_range(int'(cfg_gap_limit) + 1, 65535));
        else
            queue_gap($urandom_range(0, 65535));
        while (budget > 0)
        begin
            if ($urandom_range(0, 24) == 0)
                return;
            if ($urandom_range(0, 15) == 0)
                zeros = budget + $urandom_range(0, 2);
            else
                zeros = $urandom_range(0, (budget - 1 < 3) ? budget - 1 : 3);
            queue_gap(gap_for_zeros(zeros));
            budget -= zeros + 1;
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_GAP_LIMIT:      cfg_gap_limit = value;
            REG_TOLERANCE:      cfg_tolerance = value[SMALL_W-1:0];
            REG_ZERO_THRESHOLD: cfg_zero_threshold = value;
            REG_SLOT_LENGTH:    cfg_slot_length = value[SMALL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [TIME_W-1:0] gl, input logic [SMALL_W-1:0] tol,
                                  input logic [TIME_W-1:0] zt, input logic [SMALL_W-1:0] sl);
        write_reg(REG_GAP_LIMIT, gl);
        write_reg(REG_TOLERANCE, {8'd0, tol});
        write_reg(REG_ZERO_THRESHOLD, zt);
        write_reg(REG_SLOT_LENGTH, {8'd0, sl});
    endtask

    // Waits until every request is taken and every byte is back, then lets
    // an edge that completes nothing finish its slot counting.
    task automatic drain();
        do
            @(posedge clk);
        while (pending_times.size() != 0 || pulse_ch.valid || expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int count, input bit calm);
        int start;
        start = queued_total;
        if (calm)
        begin
            idle_odds  = 0;
            stall_odds = 0;
        end
        else
        begin
            idle_odds  = $urandom_range(0, 2) * 4;
            stall_odds = $urandom_range(0, 2) * 4;
        end
        while (queued_total - start < count)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_gap($urandom_range(0, 65535));
            else
                queue_frame();
        end
        drain();
    endtask

    // Edge request driver.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pulse_ch.valid && pulse_ch.ready)
                predict_edge(pulse_ch.edge_time);
            if (!pulse_ch.valid || pulse_ch.ready)
            begin
                if (idle_left != 0)
                begin
                    idle_left--;
                    pulse_ch.valid <= 1'b0;
                end
                else if (pending_times.size() != 0 && idle_odds != 0 &&
                         $urandom_range(0, idle_odds - 1) == 0)
                begin
                    idle_left = $urandom_range(0, 16);
                    pulse_ch.valid <= 1'b0;
                end
                else if (pending_times.size() != 0)
                begin
                    pulse_ch.valid     <= 1'b1;
                    pulse_ch.edge_time <= pending_times.pop_front();
                end
                else
                    pulse_ch.valid <= 1'b0;
            end
        end
    end

    // Byte monitor with random back-pressure.
    always @(posedge clk)
    begin : byte_monitor
        logic [BYTE_W-1:0] want;
        if (rst_n)
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                        $display("unexpected received_byte %02h", byte_ch.received_byte);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (byte_ch.received_byte !== want)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_MAX)
                            $display("received_byte mismatch: expected %02h, got %02h",
                                     want, byte_ch.received_byte);
                    end
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                byte_ch.ready <= 1'b0;
            end
            else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0)
            begin
                stall_left = $urandom_range(0, 16);
                byte_ch.ready <= 1'b0;
            end
            else
                byte_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        pulse_ch.valid     = 1'b0;
        pulse_ch.edge_time = '0;
        byte_ch.ready      = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed edges under the reset settings: a full frame of ones,
        // a restart across the timestamp wrap, one- and two-slot zeros,
        // a frame that overshoots its last stage, and zero gaps.
        idle_odds  = 4;
        stall_odds = 4;
        foreach (directed_times[i])
        begin
            pending_times.push_back(directed_times[i][TIME_W-1:0]);
            queued_total++;
        end
        next_time = directed_times[directed_times.size() - 1][TIME_W-1:0];
        drain();

        apply_settings(16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF);
        run_random(80, 1'b0);
        apply_settings(16'h0000, 8'h00, 16'h0000, 8'h01);
        run_random(60, 1'b0);
        // Single-millisecond slots make most edges count many zeros.
        apply_settings(16'd2000, 8'd0, 16'd10, 8'd1);
        run_random(60, 1'b0);
        // Slots longer than what is left of the gap saturate at zero.
        apply_settings(16'd500, 8'd3, 16'd40, 8'd200);
        run_random(60, 1'b0);
        apply_settings(GAP_LIMIT_RST, TOLERANCE_RST, ZERO_THRESHOLD_RST, SLOT_LENGTH_RST);
        run_random(90, 1'b0);
        for (int p = 0; p < 5; p++)
        begin
            apply_settings(16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                         : $urandom_range(30, 3000)),
                           8'($urandom_range(0, 255)), 16'($urandom_range(0, 1000)),
                           8'($urandom_range(1, 255)));
            run_random(80, p == 4);
        end

        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
